// ----- hdl/lbas_pkg.sv -----
// ----------------------------------------------------------------------------
// lbas_pkg: shared types and constants for the log2-binned allocation stats
// Beat types for the command port, the registered input beat, function codes
// and the thread-id fold used by the histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package lbas_pkg;

  // width of the used+wasted sum and of the decremented sizes
  localparam int SUM_W     = 33;
  // thread mask width and the folded thread-id width
  localparam int THREADS   = 63;
  localparam int TID_MOD_W = 6;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2
  } lbas_func_e;

  // command beat
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] used;
    logic [31:0] allocated;
    logic [31:0] wasted;
    logic [31:0] thread_id;
    logic [3:0]  read_bin;
  } lbas_in_t;

  // result beat
  typedef struct packed {
    logic [63:0]        bin_alloc_count;
    logic [63:0]        bin_alloc_bytes;
    logic [63:0]        bin_used_bytes;
    logic [63:0]        bin_wasted_bytes;
    logic [31:0]        largest_block;
    logic [THREADS-1:0] thread_mask;
  } lbas_out_t;

  // input register contents: raw fields plus pre-decremented sizes
  typedef struct packed {
    logic [1:0]           func;
    logic [31:0]          used;
    logic [31:0]          allocated;
    logic [31:0]          wasted;
    logic [SUM_W-1:0]     alloc_dec;
    logic                 alloc_zero;
    logic [SUM_W-1:0]     pair_dec;
    logic                 pair_zero;
    logic [TID_MOD_W-1:0] tid_mod;
    logic [3:0]           read_bin;
  } lbas_beat_t;

  // v mod 63: since 64 = 1 (mod 63), sum the 6-bit digits, fold once more,
  // then one conditional subtract
  function automatic logic [TID_MOD_W-1:0] mod63(logic [31:0] v);
    logic [8:0] s1;
    logic [6:0] s2;
    s1 = 9'(v[5:0]) + 9'(v[11:6]) + 9'(v[17:12]) + 9'(v[23:18])
       + 9'(v[29:24]) + 9'(v[31:30]);
    s2 = 7'(s1[5:0]) + 7'(s1[8:6]);
    if (s2 >= 7'(THREADS)) begin
      s2 = s2 - 7'(THREADS);
    end
    return s2[TID_MOD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/log2_binned_allocation_stats.sv -----
// ----------------------------------------------------------------------------
// log2_binned_allocation_stats: power-of-two binned allocation histogram
// Record beats update one bin's count and bytes and the used+wasted bin's used
// and wasted bytes, plus max size and a thread mask; read beats report a bin.
// ----------------------------------------------------------------------------
// A read beat passes the input register, then the result register, to done_o.
// Throughput: one beat per cycle; busy stays low, every beat takes one pass
// through the bin read-modify-write between input and result registers.
// Reset: all bins, the max and the thread mask clear at once; no sweep.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module log2_binned_allocation_stats import lbas_pkg::*; #(
  parameter int BINS         = 16,
  parameter int LOG_BIN_ZERO = 7
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lbas_in_t  in_i,
  output logic      done_o,
  output lbas_out_t res_o
);

  localparam int BW = $clog2(BINS);

  logic               accept;
  lbas_beat_t         beat_d;
  lbas_beat_t         beat_q;
  logic               in_vld_q;

  logic [BW-1:0]      alloc_bin;
  logic [BW-1:0]      pair_bin;
  logic               is_rec;
  logic               is_read;
  logic               is_clear;
  logic               rd_ok;
  logic [BW-1:0]      rd_idx;
  logic [BW-1:0]      sel_a;
  logic [BW-1:0]      sel_p;

  logic [63:0]        cnt_q    [BINS];
  logic [63:0]        abytes_q [BINS];
  logic [63:0]        ubytes_q [BINS];
  logic [63:0]        wbytes_q [BINS];
  logic [63:0]        cnt_rd;
  logic [63:0]        abytes_rd;
  logic [63:0]        ubytes_rd;
  logic [63:0]        wbytes_rd;
  logic [63:0]        cnt_d;
  logic [63:0]        abytes_d;
  logic [63:0]        ubytes_d;
  logic [63:0]        wbytes_d;

  logic [31:0]        max_q;
  logic [31:0]        max_d;
  logic [THREADS-1:0] mask_q;
  logic [THREADS-1:0] thr_bit;

  logic               done_q;
  lbas_out_t          res_q;

  // every beat finishes in one pass, so the port is never held off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // front end: pre-decrement sizes, form used+wasted, fold thread id
  always_comb begin
    beat_d.func       = in_i.func;
    beat_d.used       = in_i.used;
    beat_d.allocated  = in_i.allocated;
    beat_d.wasted     = in_i.wasted;
    beat_d.alloc_dec  = SUM_W'(in_i.allocated) - SUM_W'(1);
    beat_d.alloc_zero = (in_i.allocated == '0);
    beat_d.pair_dec   = SUM_W'(in_i.used) + SUM_W'(in_i.wasted) - SUM_W'(1);
    beat_d.pair_zero  = (in_i.used == '0) && (in_i.wasted == '0);
    beat_d.tid_mod    = mod63(in_i.thread_id);
    beat_d.read_bin   = in_i.read_bin;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q <= beat_d;
    end
  end

  // bin selection for the allocated size and for used+wasted
  lbas_bin_sel #(
    .BINS         (BINS),
    .LOG_BIN_ZERO (LOG_BIN_ZERO)
  ) u_alloc_bin (
    .dec_i  (beat_q.alloc_dec),
    .zero_i (beat_q.alloc_zero),
    .bin_o  (alloc_bin)
  );

  lbas_bin_sel #(
    .BINS         (BINS),
    .LOG_BIN_ZERO (LOG_BIN_ZERO)
  ) u_pair_bin (
    .dec_i  (beat_q.pair_dec),
    .zero_i (beat_q.pair_zero),
    .bin_o  (pair_bin)
  );

  // decode the registered beat
  assign is_rec   = in_vld_q && (beat_q.func == FUNC_RECORD);
  assign is_read  = in_vld_q && (beat_q.func == FUNC_READ);
  assign is_clear = in_vld_q && (beat_q.func == FUNC_CLEAR);
  assign rd_ok    = int'(beat_q.read_bin) < BINS;
  assign rd_idx   = BW'(beat_q.read_bin);

  // one read port per bin array, shared by record and read beats
  assign sel_a     = is_read ? rd_idx : alloc_bin;
  assign sel_p     = is_read ? rd_idx : pair_bin;
  assign cnt_rd    = cnt_q[sel_a];
  assign abytes_rd = abytes_q[sel_a];
  assign ubytes_rd = ubytes_q[sel_p];
  assign wbytes_rd = wbytes_q[sel_p];

  // bin updates, wrapping at 64 bits
  assign cnt_d    = cnt_rd + 64'd1;
  assign abytes_d = abytes_rd + 64'(beat_q.allocated);
  assign ubytes_d = ubytes_rd + 64'(beat_q.used);
  assign wbytes_d = wbytes_rd + 64'(beat_q.wasted);

  assign max_d   = (max_q < beat_q.allocated) ? beat_q.allocated : max_q;
  assign thr_bit = THREADS'(1) << beat_q.tid_mod;

  // statistics state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BINS; b++) begin
        cnt_q[b]    <= '0;
        abytes_q[b] <= '0;
        ubytes_q[b] <= '0;
        wbytes_q[b] <= '0;
      end
      max_q  <= '0;
      mask_q <= '0;
    end else if (is_clear) begin
      for (int b = 0; b < BINS; b++) begin
        cnt_q[b]    <= '0;
        abytes_q[b] <= '0;
        ubytes_q[b] <= '0;
        wbytes_q[b] <= '0;
      end
      max_q  <= '0;
      mask_q <= '0;
    end else if (is_rec) begin
      cnt_q[alloc_bin]    <= cnt_d;
      abytes_q[alloc_bin] <= abytes_d;
      ubytes_q[pair_bin]  <= ubytes_d;
      wbytes_q[pair_bin]  <= wbytes_d;
      max_q               <= max_d;
      mask_q              <= mask_q | thr_bit;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      res_q.bin_alloc_count  <= rd_ok ? cnt_rd    : '0;
      res_q.bin_alloc_bytes  <= rd_ok ? abytes_rd : '0;
      res_q.bin_used_bytes   <= rd_ok ? ubytes_rd : '0;
      res_q.bin_wasted_bytes <= rd_ok ? wbytes_rd : '0;
      res_q.largest_block    <= max_q;
      res_q.thread_mask      <= mask_q;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // a strobe only follows a read beat
  a_done_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(is_read))
    else $error("result strobe without a read beat");

  // a clear leaves max and mask at zero
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_clear |=> (max_q == '0) && (mask_q == '0))
    else $error("clear did not zero max or mask");

  // a record sets its thread bit
  a_thread_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_rec |=> ((mask_q & $past(thr_bit)) != '0))
    else $error("thread bit not set after record");

  // the max never trails a recorded size
  a_max_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_rec |=> (max_q >= $past(beat_q.allocated)))
    else $error("largest block below a recorded size");

endmodule

`default_nettype wire

// ----- hdl/lbas_bin_sel.sv -----
// ----------------------------------------------------------------------------
// lbas_bin_sel: power-of-two bin index from a decremented size
// Takes size-1 and a zero flag; bin is ceil(log2 size) - LOG_BIN_ZERO,
// clamped to bin 0 below and to the last bin above.
// ----------------------------------------------------------------------------
`default_nettype none

module lbas_bin_sel import lbas_pkg::*; #(
  parameter int BINS         = 16,
  parameter int LOG_BIN_ZERO = 7,
  localparam int BW          = $clog2(BINS)
) (
  input  logic [SUM_W-1:0] dec_i,
  input  logic             zero_i,
  output logic [BW-1:0]    bin_o
);

  localparam int WW  = $clog2(SUM_W + 1);
  localparam int PEN = LOG_BIN_ZERO + BINS - 2;

  logic [WW-1:0] sig_w;

  // significant-bit count of size-1, i.e. ceil(log2 size)
  always_comb begin
    sig_w = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (dec_i[i]) begin
        sig_w = WW'(i + 1);
      end
    end
  end

  // clamp into the bin range
  always_comb begin
    if (zero_i || (int'(sig_w) <= LOG_BIN_ZERO)) begin
      bin_o = '0;
    end else if (int'(sig_w) > PEN) begin
      bin_o = BW'(BINS - 1);
    end else begin
      bin_o = BW'(int'(sig_w) - LOG_BIN_ZERO);
    end
  end

endmodule

`default_nettype wire
